FILE: hw/rtl/mcstb_pkg.sv
// Shared types and constants for the multi-channel soft timer bank.
// No dependencies; used by multi_channel_soft_timer_bank_core.
package mcstb_pkg;

  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned MS_W        = 32;
  localparam int unsigned US_W        = 10;
  localparam int unsigned PERIOD_W    = 32;
  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam int unsigned RECIP_1000  = 32'h1062_4DD3;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned RAM_W       = MS_W + US_W + PERIOD_W;
  localparam int unsigned IN_DATA_W   = 88;
  localparam int unsigned OUT_DATA_W  = 8;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_NONE    = 2'd3
  } run_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_RESP,
    S_LOAD,
    S_DIV,
    S_ARM,
    S_URD,
    S_UEVAL,
    S_UCMP,
    S_NEXT,
    S_FLUSH
  } seq_e;

endpackage

FILE: hw/rtl/mcstb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds per-timer due time and reload period.
module mcstb_ram #(
  parameter int unsigned WIDTH = 74,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/multi_channel_soft_timer_bank_core.sv
// Bank of TIMER_COUNT software timers (one-shot or cyclic) driven by request commands.
// Stop, query and a refused start go from decode to the response state, which loads their
// result once the output register is free; the next request is then accepted. A start that
// arms steps through decode, multiply by the reciprocal of 1000, remainder plus microseconds,
// RAM write and respond. Update walks the timers one at a time through the due-time RAM (one
// read per timer): read, evaluate, then compare for a running timer or reload and rearm for
// an expired cyclic one, then advance, with a decode first and a flush at the end; a fired
// result waits only when the output register is still full. Depends on mcstb_pkg and mcstb_ram.
module multi_channel_soft_timer_bank_core #(
  parameter int unsigned TIMER_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // timer_id[7:0], mode_sel[9:8], period_us[41:10], now_ms[73:42], now_us[83:74]
  input  logic [87:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // reply_ok[0], timer_state[2:1], fired_id[5:3]
  output logic [7:0]  m_axis_tdata,
  // fired[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

  mcstb_pkg::seq_e state_q, state_d;
  mcstb_pkg::cmd_e cmd_q, cmd_d;
  mcstb_pkg::run_e run_q [TIMER_COUNT];
  logic            cyc_q [TIMER_COUNT];

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             id_ok_q, id_ok_d;
  logic [1:0]       mode_q, mode_d;
  logic [31:0]      period_q, period_d;
  logic [31:0]      ms_q, ms_d;
  logic [9:0]       us_q, us_d;
  logic [31:0]      prod_q, prod_d;
  logic [31:0]      div_q, div_d;
  logic [10:0]      rem_q, rem_d;
  logic [3:0]       nres_q, nres_d;
  logic             pend_q, pend_d;
  logic [2:0]       pend_id_q, pend_id_d;
  logic             hold_ok_q, hold_ok_d;
  logic [1:0]       hold_st_q, hold_st_d;

  logic       out_valid_q, out_valid_d;
  logic       o_ok_q, o_ok_d;
  logic [1:0] o_st_q, o_st_d;
  logic       o_fired_q, o_fired_d;
  logic [2:0] o_id_q, o_id_d;
  logic       o_last_q, o_last_d;

  logic                    run_we, cyc_we, cyc_wd, ram_we;
  mcstb_pkg::run_e         run_wd;
  logic [mcstb_pkg::RAM_W-1:0] ram_wdata, ram_rdata;
  logic [31:0]             rd_ms, rd_rel, diff;
  logic [9:0]              rd_us;
  logic [63:0]             recip_prod;
  logic [1:0]              carry;
  logic [9:0]              due_us;
  logic                    in_acc, out_free;

  assign rd_ms  = ram_rdata[31:0];
  assign rd_us  = ram_rdata[41:32];
  assign rd_rel = ram_rdata[73:42];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == mcstb_pkg::S_IDLE);

  assign diff     = prod_q + 32'(us_q) - 32'(rd_us);

  // quotient of the period by 1000; remainder plus now_us stays below 2023
  assign recip_prod = 64'(period_q) * 64'(mcstb_pkg::RECIP_1000);
  assign carry  = (rem_q >= 11'(2 * mcstb_pkg::US_PER_MS)) ? 2'd2 :
                  (rem_q >= 11'(mcstb_pkg::US_PER_MS))     ? 2'd1 : 2'd0;
  assign due_us = (carry == 2'd2) ? 10'(rem_q - 11'(2 * mcstb_pkg::US_PER_MS)) :
                  (carry == 2'd1) ? 10'(rem_q - 11'(mcstb_pkg::US_PER_MS)) : rem_q[9:0];

  assign ram_wdata = {period_q, due_us, ms_q + div_q + 32'(carry)};

  mcstb_ram #(
    .WIDTH(mcstb_pkg::RAM_W),
    .DEPTH(TIMER_COUNT)
  ) u_due_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(ram_wdata),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    id_ok_d     = id_ok_q;
    mode_d      = mode_q;
    period_d    = period_q;
    ms_d        = ms_q;
    us_d        = us_q;
    prod_d      = prod_q;
    div_d       = div_q;
    rem_d       = rem_q;
    nres_d      = nres_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    hold_ok_d   = hold_ok_q;
    hold_st_d   = hold_st_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    o_ok_d      = o_ok_q;
    o_st_d      = o_st_q;
    o_fired_d   = o_fired_q;
    o_id_d      = o_id_q;
    o_last_d    = o_last_q;
    run_we      = 1'b0;
    run_wd      = mcstb_pkg::ST_STOPPED;
    cyc_we      = 1'b0;
    cyc_wd      = 1'b0;
    ram_we      = 1'b0;

    case (state_q)
      mcstb_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_d    = mcstb_pkg::cmd_e'(s_axis_tuser);
          id_ok_d  = {1'b0, s_axis_tdata[7:0]} < 9'(TIMER_COUNT);
          idx_d    = (cmd_d == mcstb_pkg::CMD_UPDATE) ? '0 : s_axis_tdata[IDX_W-1:0];
          mode_d   = s_axis_tdata[9:8];
          period_d = s_axis_tdata[41:10];
          ms_d     = s_axis_tdata[73:42];
          us_d     = s_axis_tdata[83:74];
          nres_d   = '0;
          pend_d   = 1'b0;
          state_d  = mcstb_pkg::S_CMD;
        end
      end
      mcstb_pkg::S_CMD: begin
        hold_ok_d = 1'b0;
        hold_st_d = mcstb_pkg::ST_STOPPED;
        state_d   = mcstb_pkg::S_RESP;
        case (cmd_q)
          mcstb_pkg::CMD_START: begin
            if (id_ok_q && !mode_q[1] && run_q[idx_q] == mcstb_pkg::ST_STOPPED) begin
              state_d = mcstb_pkg::S_LOAD;
            end
          end
          mcstb_pkg::CMD_STOP: begin
            hold_ok_d = id_ok_q;
            run_we    = id_ok_q;
            run_wd    = mcstb_pkg::ST_STOPPED;
          end
          mcstb_pkg::CMD_QUERY: begin
            hold_st_d = id_ok_q ? run_q[idx_q] : mcstb_pkg::ST_NONE;
          end
          default: begin
            state_d = mcstb_pkg::S_UEVAL;
          end
        endcase
      end
      mcstb_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_ok_d      = hold_ok_q;
          o_st_d      = hold_st_q;
          o_fired_d   = 1'b0;
          o_id_d      = '0;
          o_last_d    = 1'b1;
          state_d     = mcstb_pkg::S_IDLE;
        end
      end
      mcstb_pkg::S_LOAD: begin
        div_d   = 32'(recip_prod >> mcstb_pkg::RECIP_SHIFT);
        state_d = mcstb_pkg::S_DIV;
      end
      mcstb_pkg::S_DIV: begin
        rem_d   = 11'(period_q - div_q * 32'(mcstb_pkg::US_PER_MS)) + 11'(us_q);
        state_d = mcstb_pkg::S_ARM;
      end
      mcstb_pkg::S_ARM: begin
        ram_we = 1'b1;
        run_we = 1'b1;
        run_wd = mcstb_pkg::ST_RUNNING;
        if (cmd_q == mcstb_pkg::CMD_START) begin
          cyc_we    = 1'b1;
          cyc_wd    = mode_q[0];
          hold_ok_d = 1'b1;
          hold_st_d = mcstb_pkg::ST_STOPPED;
          state_d   = mcstb_pkg::S_RESP;
        end else begin
          state_d = mcstb_pkg::S_NEXT;
        end
      end
      mcstb_pkg::S_URD: begin
        state_d = mcstb_pkg::S_UEVAL;
      end
      mcstb_pkg::S_UEVAL: begin
        state_d = mcstb_pkg::S_NEXT;
        case (run_q[idx_q])
          mcstb_pkg::ST_RUNNING: begin
            prod_d  = 32'((ms_q - rd_ms) * 32'(mcstb_pkg::US_PER_MS));
            state_d = mcstb_pkg::S_UCMP;
          end
          mcstb_pkg::ST_TIMEOUT: begin
            if (cyc_q[idx_q]) begin
              period_d = rd_rel;
              state_d  = mcstb_pkg::S_LOAD;
            end else begin
              run_we = 1'b1;
              run_wd = mcstb_pkg::ST_STOPPED;
            end
          end
          default: begin
            state_d = mcstb_pkg::S_NEXT;
          end
        endcase
      end
      mcstb_pkg::S_UCMP: begin
        if (diff[31]) begin
          state_d = mcstb_pkg::S_NEXT;
        end else if (nres_q >= 4'(mcstb_pkg::MAX_RESULTS)) begin
          run_we  = 1'b1;
          run_wd  = mcstb_pkg::ST_TIMEOUT;
          state_d = mcstb_pkg::S_NEXT;
        end else if (!pend_q || out_free) begin
          if (pend_q) begin
            out_valid_d = 1'b1;
            o_ok_d      = 1'b1;
            o_st_d      = mcstb_pkg::ST_TIMEOUT;
            o_fired_d   = 1'b1;
            o_id_d      = pend_id_q;
            o_last_d    = 1'b0;
          end
          pend_d    = 1'b1;
          pend_id_d = 3'(idx_q);
          nres_d    = nres_q + 4'd1;
          run_we    = 1'b1;
          run_wd    = mcstb_pkg::ST_TIMEOUT;
          state_d   = mcstb_pkg::S_NEXT;
        end
      end
      mcstb_pkg::S_NEXT: begin
        if (idx_q == LAST_IDX) begin
          state_d = mcstb_pkg::S_FLUSH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = mcstb_pkg::S_URD;
        end
      end
      mcstb_pkg::S_FLUSH: begin
        if (!pend_q) begin
          state_d = mcstb_pkg::S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          o_ok_d      = 1'b1;
          o_st_d      = mcstb_pkg::ST_TIMEOUT;
          o_fired_d   = 1'b1;
          o_id_d      = pend_id_q;
          o_last_d    = 1'b1;
          pend_d      = 1'b0;
          state_d     = mcstb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mcstb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcstb_pkg::S_IDLE;
      cmd_q       <= mcstb_pkg::CMD_START;
      idx_q       <= '0;
      nres_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        run_q[i] <= mcstb_pkg::ST_STOPPED;
        cyc_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      idx_q       <= idx_d;
      nres_q      <= nres_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (run_we) begin
        run_q[idx_q] <= run_wd;
      end
      if (cyc_we) begin
        cyc_q[idx_q] <= cyc_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_ok_q   <= id_ok_d;
    mode_q    <= mode_d;
    period_q  <= period_d;
    ms_q      <= ms_d;
    us_q      <= us_d;
    prod_q    <= prod_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    pend_id_q <= pend_id_d;
    hold_ok_q <= hold_ok_d;
    hold_st_q <= hold_st_d;
    o_ok_q    <= o_ok_d;
    o_st_q    <= o_st_d;
    o_fired_q <= o_fired_d;
    o_id_q    <= o_id_d;
    o_last_q  <= o_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, o_id_q, o_st_q, o_ok_q};
  assign m_axis_tuser  = o_fired_q;
  assign m_axis_tlast  = o_last_q;

  a_nres_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= 4'(mcstb_pkg::MAX_RESULTS))
    else $error("fired count above limit");

  a_pend_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> cmd_q == mcstb_pkg::CMD_UPDATE)
    else $error("pending fired result outside update");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcstb_pkg::S_ARM |-> due_us < 10'(mcstb_pkg::US_PER_MS))
    else $error("due microseconds out of range");

  a_accept_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == mcstb_pkg::S_CMD)
    else $error("request not decoded after accept");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for multi_channel_soft_timer_bank_core: directed and random
// start/stop/query/update requests against a cycle-free predictor of the timer bank.
// Depends on mcstb_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_TIMERS  = 8;
  localparam int unsigned RAND_ITEMS  = 345;
  localparam int unsigned END_SLACK   = 400;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SHOW_ERRORS = 10;
  localparam bit [1:0]    MODE_ONESHOT = 2'd0;
  localparam bit [1:0]    MODE_CYCLIC  = 2'd1;

  typedef struct packed {
    logic            ok;
    mcstb_pkg::run_e st;
    logic            fired;
    logic [2:0]      fid;
    logic            last;
  } reply_t;

  class timer_reply_board;
    mcstb_pkg::run_e tstate [NUM_TIMERS];
    bit              tcyclic[NUM_TIMERS];
    bit [31:0]       tdue_ms[NUM_TIMERS];
    bit [9:0]        tdue_us[NUM_TIMERS];
    bit [31:0]       treload[NUM_TIMERS];
    reply_t          due_replies[$];
    int              fail_count;

    function new();
      for (int k = 0; k < NUM_TIMERS; k++) begin
        tstate[k]  = mcstb_pkg::ST_STOPPED;
        tcyclic[k] = 1'b0;
        tdue_ms[k] = '0;
        tdue_us[k] = '0;
        treload[k] = '0;
      end
      fail_count = 0;
    endfunction

    // due = now + period, exact microsecond sum
    function void arm(int k, bit [31:0] ms, bit [9:0] us, bit [31:0] per);
      bit [32:0] total;
      total      = 33'(us) + 33'(per);
      tdue_ms[k] = ms + 32'(total / mcstb_pkg::US_PER_MS);
      tdue_us[k] = 10'(total % mcstb_pkg::US_PER_MS);
    endfunction

    function bit reached(int k, bit [31:0] ms, bit [9:0] us);
      bit [31:0] d;
      d = (ms - tdue_ms[k]) * mcstb_pkg::US_PER_MS + 32'(us) - 32'(tdue_us[k]);
      return !d[31];
    endfunction

    function void accept_request(mcstb_pkg::cmd_e c, bit [7:0] id, bit [1:0] mode,
                                 bit [31:0] per, bit [31:0] ms, bit [9:0] us);
      reply_t r;
      reply_t fires[$];
      bit     valid;
      valid = id < NUM_TIMERS;
      r = '{ok: 1'b0, st: mcstb_pkg::ST_STOPPED, fired: 1'b0, fid: 3'd0, last: 1'b1};
      case (c)
        mcstb_pkg::CMD_START: begin
          if (valid && mode <= MODE_CYCLIC && tstate[id] == mcstb_pkg::ST_STOPPED) begin
            tstate[id]  = mcstb_pkg::ST_RUNNING;
            tcyclic[id] = mode[0];
            arm(id, ms, us, per);
            treload[id] = per;
            r.ok = 1'b1;
          end
          due_replies.push_back(r);
        end
        mcstb_pkg::CMD_STOP: begin
          if (valid) begin
            tstate[id] = mcstb_pkg::ST_STOPPED;
          end
          r.ok = valid;
          due_replies.push_back(r);
        end
        mcstb_pkg::CMD_QUERY: begin
          r.st = valid ? tstate[id] : mcstb_pkg::ST_NONE;
          due_replies.push_back(r);
        end
        default: begin
          for (int k = 0; k < NUM_TIMERS; k++) begin
            if (tstate[k] == mcstb_pkg::ST_RUNNING) begin
              if (reached(k, ms, us)) begin
                tstate[k] = mcstb_pkg::ST_TIMEOUT;
                if (fires.size() < mcstb_pkg::MAX_RESULTS) begin
                  fires.push_back('{ok: 1'b1, st: mcstb_pkg::ST_TIMEOUT, fired: 1'b1,
                                    fid: 3'(k), last: 1'b0});
                end
              end
            end else if (tstate[k] == mcstb_pkg::ST_TIMEOUT) begin
              if (!tcyclic[k]) begin
                tstate[k] = mcstb_pkg::ST_STOPPED;
              end else begin
                arm(k, ms, us, treload[k]);
                tstate[k] = mcstb_pkg::ST_RUNNING;
              end
            end
          end
          if (fires.size() > 0) begin
            fires[fires.size()-1].last = 1'b1;
          end
          foreach (fires[i]) due_replies.push_back(fires[i]);
        end
      endcase
    endfunction

    function void flag(string what, reply_t want, reply_t got);
      fail_count++;
      if (fail_count <= SHOW_ERRORS) begin
        $display("%t %s: expected ok=%0d st=%0d fired=%0d id=%0d last=%0d,",
                 $realtime, what, want.ok, want.st, want.fired, want.fid, want.last);
        $display("    got ok=%0d st=%0d fired=%0d id=%0d last=%0d",
                 got.ok, got.st, got.fired, got.fid, got.last);
      end
    endfunction

    function void check_reply(logic [7:0] data, logic user, logic tlast);
      reply_t got;
      reply_t want;
      got = '{ok: data[0], st: mcstb_pkg::run_e'(data[2:1]), fired: user, fid: data[5:3],
              last: tlast};
      if (due_replies.size() == 0) begin
        flag("unexpected reply", '0, got);
      end else begin
        want = due_replies.pop_front();
        if (got !== want) begin
          flag("reply mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  timer_reply_board board = new();
  bit [31:0] cur_ms;
  bit [9:0]  cur_us;
  bit        quiet;

  multi_channel_soft_timer_bank_core #(
    .TIMER_COUNT(NUM_TIMERS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("multi_channel_soft_timer_bank_core regression: fail");
    $finish;
  end

  function automatic void tick(int unsigned step);
    bit [31:0] total;
    total  = 32'(cur_us) + step;
    cur_ms = cur_ms + total / mcstb_pkg::US_PER_MS;
    cur_us = 10'(total % mcstb_pkg::US_PER_MS);
  endfunction

  task automatic send_req(mcstb_pkg::cmd_e c, bit [7:0] id, bit [1:0] mode, bit [31:0] per,
                          bit [31:0] ms, bit [9:0] us);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {4'b0, us, ms, per, mode, id};
    do @(posedge clk_i); while (!s_axis_tready);
    board.accept_request(c, id, mode, per, ms, us);
  endtask

  task automatic issue(mcstb_pkg::cmd_e c, bit [7:0] id = '0, bit [1:0] mode = MODE_ONESHOT,
                       bit [31:0] per = '0);
    send_req(c, id, mode, per, cur_ms, cur_us);
  endtask

  // result side: random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 11) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_reply(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin
    int unsigned sel;
    bit [31:0]   per;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = mcstb_pkg::CMD_START;
    cur_ms        = 32'hFFFF_FFFA;  // crosses the millisecond wrap early
    cur_us        = '0;
    quiet         = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    issue(mcstb_pkg::CMD_QUERY, 8'd0);
    issue(mcstb_pkg::CMD_QUERY, 8'd255);
    issue(mcstb_pkg::CMD_START, 8'd8, MODE_ONESHOT, 32'd100);
    issue(mcstb_pkg::CMD_START, 8'd0, 2'd2, 32'd100);
    issue(mcstb_pkg::CMD_STOP, 8'd255);
    issue(mcstb_pkg::CMD_UPDATE);
    issue(mcstb_pkg::CMD_START, 8'd0, MODE_ONESHOT, 32'd0);
    issue(mcstb_pkg::CMD_START, 8'd0, MODE_CYCLIC, 32'd10);
    issue(mcstb_pkg::CMD_START, 8'd7, MODE_CYCLIC, 32'd1500);
    send_req(mcstb_pkg::CMD_START, 8'd1, MODE_CYCLIC, 32'hFFFF_FFFF, cur_ms, 10'd1023);
    issue(mcstb_pkg::CMD_QUERY, 8'd0);
    issue(mcstb_pkg::CMD_UPDATE);
    issue(mcstb_pkg::CMD_QUERY, 8'd0);
    issue(mcstb_pkg::CMD_START, 8'd0, MODE_ONESHOT, 32'd5);
    issue(mcstb_pkg::CMD_UPDATE);
    tick(2000);
    issue(mcstb_pkg::CMD_UPDATE);
    issue(mcstb_pkg::CMD_UPDATE);
    issue(mcstb_pkg::CMD_STOP, 8'd7);
    issue(mcstb_pkg::CMD_STOP, 8'd1);
    // every timer expires in one update
    for (int k = 0; k < NUM_TIMERS; k++) begin
      issue(mcstb_pkg::CMD_START, 8'(k), (k % 2) ? MODE_CYCLIC : MODE_ONESHOT, 32'd0);
    end
    issue(mcstb_pkg::CMD_UPDATE);
    issue(mcstb_pkg::CMD_UPDATE);

    // random
    for (int i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i % 100 >= 85) || (i >= RAND_ITEMS - 50);
      sel   = $urandom_range(0, 99);
      if (sel < 40) begin
        tick(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2500));
        issue(mcstb_pkg::CMD_UPDATE);
      end else if (sel < 68) begin
        per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6000);
        issue(mcstb_pkg::CMD_START, 8'($urandom_range(0, NUM_TIMERS - 1)),
              2'($urandom_range(0, 1)), per);
      end else if (sel < 78) begin
        issue(mcstb_pkg::CMD_QUERY, 8'($urandom_range(0, NUM_TIMERS - 1)));
      end else if (sel < 86) begin
        issue(mcstb_pkg::CMD_STOP, 8'($urandom_range(0, NUM_TIMERS - 1)));
      end else begin
        send_req(mcstb_pkg::cmd_e'($urandom_range(0, 3)), 8'($urandom), 2'($urandom),
                 $urandom, $urandom, 10'($urandom));
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.due_replies.size() != 0) @(posedge clk_i);
    repeat (END_SLACK) @(posedge clk_i);
    if (board.fail_count == 0) begin
      $display("multi_channel_soft_timer_bank_core regression: pass");
    end else begin
      $display("multi_channel_soft_timer_bank_core regression: fail");
    end
    $finish;
  end

endmodule
